>>> rtl/substitution_container_decoder_unit_assert.svh
// assertion macros for the decoder rtl
`ifndef SUBSTITUTION_CONTAINER_DECODER_UNIT_ASSERT_SVH
`define SUBSTITUTION_CONTAINER_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scd assertion failed");

// next-cycle implication, held off while reset is low
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scd assertion failed");

`endif

>>> rtl/scd_pkg.sv
// shared types and constants of the substitution container decoder
`timescale 1ns / 1ps

package scd_pkg;

    localparam int MAGIC_BYTES = 7;
    localparam int MAGIC_W     = 8 * MAGIC_BYTES;
    localparam int TABLE_SIZE  = 256;
    localparam int TABLE_AW    = $clog2(TABLE_SIZE);
    localparam int HDR_BYTES   = MAGIC_BYTES + 1;
    localparam int HDR_AW      = $clog2(HDR_BYTES);

    // "ENCLITE" in ascii, first byte most significant
    localparam logic [55:0] MAGIC_RESET = 56'h454E434C495445;

    // configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic [1:0] status;
        logic       last_result;
    } t_out_beat;

endpackage

>>> rtl/substitution_container_decoder_unit.sv
// top level of the substitution container decoder
`timescale 1ns / 1ps

// Decrypts a byte-substitution container file streamed one byte per beat.
// Input channel: i_in_valid / o_in_ready with i_in_data (byte and end-of-file
// mark). Output channel: o_out_valid / i_out_ready with o_out_data (plain
// byte, status, last flag). Configuration: i_cfg_we writes i_cfg_wdata to the
// register i_cfg_idx selects (0 magic word, 1 format version); write it only
// while the block is idle.
// Header bytes are checked against the magic and version, the next 256 bytes
// fill the key table, and every later byte is looked up in that table.
// Header and key bytes give no result unless they end the file early or the
// header mismatches; after a mismatch the rest of the file is dropped.
// A result beat shows on the output the cycle after its input beat is taken.
// Throughput is one byte per cycle while the receiver keeps up; the key table
// has one write port and one read port, used in the key and data phases.
// When the receiver stalls, the output register holds its beat and the input
// is held off until it drains. Reset returns to the header phase and restores
// the register reset values; the key table is not cleared and needs no sweep.
module substitution_container_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  scd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scd_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [55:0]        i_cfg_wdata
);
    import scd_pkg::*;

    `include "substitution_container_decoder_unit_assert.svh"

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_KEY    = 2'd1,
        PH_DATA   = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [TABLE_AW-1:0] r_count, n_count;
    logic [MAGIC_W-1:0]  r_magic;
    logic [7:0]          r_version;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_status, n_status;
    logic                r_last, n_last;
    logic                r_is_data, n_is_data;

    logic                in_acc;
    logic                emit;
    logic [HDR_AW-1:0]   hdr_pos;
    logic [HDR_AW-1:0]   hdr_sel;
    logic [7:0]          exp_byte;
    logic                ram_we;
    logic                ram_re;
    logic [7:0]          ram_q;

    // output register frees up when empty or drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // expected header byte at the current position
    assign hdr_pos = r_count[HDR_AW-1:0];
    assign hdr_sel = HDR_AW'(MAGIC_BYTES - 1) - hdr_pos;
    always_comb begin
        if (hdr_pos >= HDR_AW'(MAGIC_BYTES)) begin
            exp_byte = r_version;
        end else begin
            exp_byte = r_magic[{hdr_sel, 3'b000} +: 8];
        end
    end

    // key table accesses
    assign ram_we = in_acc && (r_phase == PH_KEY);
    assign ram_re = in_acc && (r_phase == PH_DATA);

    scd_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count),
        .i_wdata (i_in_data.byte_in),
        .i_re    (ram_re),
        .i_raddr (i_in_data.byte_in),
        .o_rdata (ram_q)
    );

    // phase sequencing and result decision for one beat
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        emit      = 1'b0;
        n_status  = ST_OK;
        n_last    = 1'b0;
        n_is_data = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                if (i_in_data.byte_in != exp_byte) begin
                    emit     = 1'b1;
                    n_status = ST_BAD_HDR;
                    n_last   = 1'b1;
                    n_count  = '0;
                    n_phase  = i_in_data.end_of_file ? PH_HEADER : PH_SKIP;
                end else if (i_in_data.end_of_file) begin
                    emit     = 1'b1;
                    n_status = ST_SHORT;
                    n_last   = 1'b1;
                    n_count  = '0;
                end else if (hdr_pos >= HDR_AW'(MAGIC_BYTES)) begin
                    n_phase = PH_KEY;
                    n_count = '0;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            PH_KEY: begin
                n_count = r_count + 1'b1;
                if (r_count == TABLE_AW'(TABLE_SIZE - 1)) begin
                    n_phase = i_in_data.end_of_file ? PH_HEADER : PH_DATA;
                    n_count = '0;
                end else if (i_in_data.end_of_file) begin
                    emit     = 1'b1;
                    n_status = ST_SHORT;
                    n_last   = 1'b1;
                    n_phase  = PH_HEADER;
                    n_count  = '0;
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                n_is_data = 1'b1;
                n_last    = i_in_data.end_of_file;
                if (i_in_data.end_of_file) begin
                    n_phase = PH_HEADER;
                    n_count = '0;
                end
            end
            PH_SKIP: begin
                if (i_in_data.end_of_file) begin
                    n_phase = PH_HEADER;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = PH_HEADER;
                n_count = '0;
            end
        endcase
    end

    assign n_out_valid = in_acc ? emit : (r_out_valid && !i_out_ready);

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
        end
    end

    // result payload, loaded with the beat that produces it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status  <= n_status;
            r_last    <= n_last;
            r_is_data <= n_is_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_version <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:   r_magic   <= i_cfg_wdata;
                CFG_VERSION: r_version <= i_cfg_wdata[7:0];
                default:     r_version <= r_version;
            endcase
        end
    end

    // output beat
    assign o_out_valid            = r_out_valid;
    assign o_out_data.plain_byte  = r_is_data ? ram_q : 8'd0;
    assign o_out_data.status      = r_status;
    assign o_out_data.last_result = r_last;

    // checks
    `SCD_ASSERT_NOW(a_err_is_last, i_clk, i_rst_n,
        r_out_valid && (r_status != ST_OK), r_last)
    `SCD_ASSERT_NOW(a_data_status_ok, i_clk, i_rst_n,
        r_out_valid && r_is_data, r_status == ST_OK)
    `SCD_ASSERT_NOW(a_one_ram_access, i_clk, i_rst_n, ram_we, !ram_re)
    `SCD_ASSERT_NEXT(a_eof_restarts, i_clk, i_rst_n,
        in_acc && i_in_data.end_of_file, (r_phase == PH_HEADER) && (r_count == '0))
    `SCD_ASSERT_NOW(a_header_pos_range, i_clk, i_rst_n,
        r_phase == PH_HEADER, r_count <= TABLE_AW'(MAGIC_BYTES))

endmodule

>>> rtl/scd_key_ram.sv
// key table memory: one write port, one read port with registered data
`timescale 1ns / 1ps

module scd_key_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [scd_pkg::TABLE_AW-1:0] i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic                         i_re,
    input  logic [scd_pkg::TABLE_AW-1:0] i_raddr,
    output logic [7:0]                   o_rdata
);
    import scd_pkg::*;

    logic [7:0] r_mem [TABLE_SIZE];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the substitution container decoder
`timescale 1ns / 1ps

module tb_top;
    import scd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 4;
    localparam int SET_ITEMS   = 8;

    typedef enum logic [1:0] {
        HDR_STAGE,
        KEY_STAGE,
        DATA_STAGE,
        SKIP_STAGE
    } stage_e;

    typedef enum int {
        FILE_FULL,
        FILE_EMPTY,
        FILE_KEY_SHORT,
        FILE_HDR_SHORT,
        FILE_BAD_HDR,
        FILE_NOISE
    } file_kind_e;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_MAGIC;
    logic [55:0] i_cfg_wdata = '0;

    // stimulus side
    t_in_beat    file_bytes_q[$];
    int          item_total  = 0;
    logic [55:0] stim_magic  = MAGIC_RESET;
    logic [7:0]  stim_version = 8'h00;

    // driver and receiver state
    logic        in_taken    = 1'b0;
    logic        out_taken   = 1'b0;
    logic        drv_busy    = 1'b0;
    t_in_beat    drv_beat    = '0;
    int          gap_left    = 0;
    int          in_calm     = 0;
    int          stall_left  = 0;
    int          rdy_calm    = 0;

    // decoder model state
    t_out_beat   decoded_q[$];
    stage_e      stage       = HDR_STAGE;
    int          pos         = 0;
    logic [55:0] mdl_magic   = MAGIC_RESET;
    logic [7:0]  mdl_version = 8'h00;
    logic [7:0]  key_tbl[TABLE_SIZE];

    int          fail_cnt    = 0;
    int          cycle_cnt   = 0;

    substitution_container_decoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // header byte expected at a given position: magic first, then version
    function automatic logic [7:0] header_byte_at(input logic [55:0] magic,
                                                  input logic [7:0] ver, input int p);
        if (p >= MAGIC_BYTES)
            return ver;
        return magic[(MAGIC_BYTES - 1 - p) * 8 +: 8];
    endfunction

    // wait length per beat, with occasional stretches of no waiting
    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0) begin
            calm--;
            cycles = 0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                calm = $urandom_range(10, 100);
            cycles = $urandom_range(0, 19);
        end
    endtask

    // decoder behaviour for one accepted input beat
    task automatic decode_byte(input t_in_beat b);
        t_out_beat r;
        r = '0;
        r.last_result = 1'b1;
        case (stage)
            HDR_STAGE: begin
                if (b.byte_in != header_byte_at(mdl_magic, mdl_version, pos)) begin
                    stage = b.end_of_file ? HDR_STAGE : SKIP_STAGE;
                    pos = 0;
                    r.status = ST_BAD_HDR;
                    decoded_q.push_back(r);
                end else if (b.end_of_file) begin
                    pos = 0;
                    r.status = ST_SHORT;
                    decoded_q.push_back(r);
                end else if (pos >= MAGIC_BYTES) begin
                    stage = KEY_STAGE;
                    pos = 0;
                end else begin
                    pos++;
                end
            end
            KEY_STAGE: begin
                key_tbl[pos] = b.byte_in;
                if (pos == TABLE_SIZE - 1) begin
                    // eof on the last key byte is an empty file, not an error
                    stage = b.end_of_file ? HDR_STAGE : DATA_STAGE;
                    pos = 0;
                end else if (b.end_of_file) begin
                    stage = HDR_STAGE;
                    pos = 0;
                    r.status = ST_SHORT;
                    decoded_q.push_back(r);
                end else begin
                    pos++;
                end
            end
            DATA_STAGE: begin
                r.plain_byte  = key_tbl[b.byte_in];
                r.status      = ST_OK;
                r.last_result = b.end_of_file;
                if (b.end_of_file)
                    stage = HDR_STAGE;
                decoded_q.push_back(r);
            end
            default: begin
                if (b.end_of_file) begin
                    stage = HDR_STAGE;
                    pos = 0;
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eof);
        t_in_beat beat;
        beat.byte_in     = b;
        beat.end_of_file = eof;
        file_bytes_q.push_back(beat);
        item_total++;
    endtask

    // queue one file of the given kind; every kind ends on an eof beat
    task automatic queue_file(input file_kind_e kind, input int n_a, input int n_b);
        int i;
        int key_len;
        case (kind)
            FILE_HDR_SHORT: begin
                for (i = 0; i < n_a; i++)
                    push_byte(header_byte_at(stim_magic, stim_version, i), i == n_a - 1);
            end
            FILE_BAD_HDR: begin
                for (i = 0; i < n_a; i++)
                    push_byte(header_byte_at(stim_magic, stim_version, i), 1'b0);
                push_byte(header_byte_at(stim_magic, stim_version, n_a)
                          ^ 8'($urandom_range(1, 255)), n_b == 0);
                for (i = 0; i < n_b; i++)
                    push_byte(8'($urandom_range(0, 255)), i == n_b - 1);
            end
            FILE_NOISE: begin
                for (i = 0; i < n_a; i++)
                    push_byte(8'($urandom_range(0, 255)),
                              (i == n_a - 1) || ($urandom_range(0, 3) == 0));
            end
            default: begin
                for (i = 0; i <= MAGIC_BYTES; i++)
                    push_byte(header_byte_at(stim_magic, stim_version, i), 1'b0);
                key_len = (kind == FILE_KEY_SHORT) ? n_a : TABLE_SIZE;
                for (i = 0; i < key_len; i++)
                    push_byte(8'($urandom_range(0, 255)),
                              (i == key_len - 1) && (kind != FILE_FULL));
                if (kind == FILE_FULL)
                    for (i = 0; i < n_a; i++)
                        push_byte(8'($urandom_range(0, 255)), i == n_a - 1);
            end
        endcase
    endtask

    task automatic write_reg(input logic idx, input logic [55:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_MAGIC)
            stim_magic = val;
        else
            stim_version = val[7:0];
    endtask

    // block idle: nothing queued, nothing on the bus, no result outstanding
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (file_bytes_q.size() != 0 || drv_busy || decoded_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_busy = 1'b0;
            gap_left = 0;
            i_in_valid <= 1'b0;
        end else begin
            if (in_taken) begin
                drv_busy = 1'b0;
                draw_wait(in_calm, gap_left);
            end
            if (!drv_busy) begin
                if (gap_left > 0)
                    gap_left--;
                else if (file_bytes_q.size() > 0) begin
                    drv_beat = file_bytes_q.pop_front();
                    drv_busy = 1'b1;
                end
            end
            i_in_valid <= drv_busy;
            i_in_data  <= drv_beat;
        end
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken)
                draw_wait(rdy_calm, stall_left);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: register writes, input beats and result beats
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            out_taken   <= 1'b0;
            stage       = HDR_STAGE;
            pos         = 0;
            mdl_magic   = MAGIC_RESET;
            mdl_version = 8'h00;
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAGIC)
                    mdl_magic = i_cfg_wdata;
                else
                    mdl_version = i_cfg_wdata[7:0];
            end
            if (i_in_valid && o_in_ready)
                decode_byte(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result beat: plain %02h status %0d last %0b",
                                 o_out_data.plain_byte, o_out_data.status,
                                 o_out_data.last_result);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_data.plain_byte !== want.plain_byte
                        || o_out_data.status !== want.status
                        || o_out_data.last_result !== want.last_result) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"result mismatch: plain %02h/%02h status %0d/%0d",
                                      " last %0b/%0b (expected/actual)"},
                                     want.plain_byte, o_out_data.plain_byte,
                                     want.status, o_out_data.status,
                                     want.last_result, o_out_data.last_result);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int          cfg_set;
        int          set_end;
        int          pick;
        logic [63:0] rnd_word;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (cfg_set = 0; cfg_set < 4; cfg_set++) begin
            case (cfg_set)
                0: begin
                    // reset values: mismatch then skip, mismatch on an eof beat,
                    // short header, bad version, eof on a matching version byte
                    queue_file(FILE_BAD_HDR, 0, 2);
                    queue_file(FILE_BAD_HDR, 0, 0);
                    queue_file(FILE_HDR_SHORT, 3, 0);
                    queue_file(FILE_BAD_HDR, MAGIC_BYTES, 1);
                    queue_file(FILE_HDR_SHORT, MAGIC_BYTES + 1, 0);
                    queue_file(FILE_FULL, $urandom_range(1, 60), 0);
                end
                1: begin
                    wait_drained();
                    write_reg(CFG_MAGIC, '0);
                    write_reg(CFG_VERSION, 56'hFF);
                    queue_file(FILE_EMPTY, 0, 0);
                end
                2: begin
                    wait_drained();
                    write_reg(CFG_MAGIC, '1);
                    write_reg(CFG_VERSION, 56'h00);
                    // eof on the key byte just before the last
                    queue_file(FILE_KEY_SHORT, TABLE_SIZE - 1, 0);
                end
                default: begin
                    wait_drained();
                    rnd_word = {$urandom(), $urandom()};
                    write_reg(CFG_MAGIC, rnd_word[55:0]);
                    write_reg(CFG_VERSION, 56'($urandom_range(0, 255)));
                    queue_file(FILE_FULL, $urandom_range(1, 200), 0);
                end
            endcase

            // random files of all kinds, mostly malformed
            set_end = item_total + SET_ITEMS;
            while (item_total < set_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    queue_file(FILE_FULL, ($urandom_range(0, 7) == 0)
                               ? $urandom_range(1, 200) : $urandom_range(1, 40), 0);
                else if (pick < 40)
                    queue_file(FILE_EMPTY, 0, 0);
                else if (pick < 52)
                    queue_file(FILE_KEY_SHORT, $urandom_range(1, TABLE_SIZE - 1), 0);
                else if (pick < 67)
                    queue_file(FILE_HDR_SHORT, $urandom_range(1, MAGIC_BYTES + 1), 0);
                else if (pick < 90)
                    queue_file(FILE_BAD_HDR, $urandom_range(0, MAGIC_BYTES),
                               $urandom_range(0, 20));
                else
                    queue_file(FILE_NOISE, $urandom_range(1, 10), 0);
            end
        end

        wait_drained();
        if (fail_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
